// ----- rtl/pbg_pkg.sv -----
// ----------------------------------------------------------------------------
// pbg_pkg
// Shared types and constants for the run-length pixel to glyph code stream
// decoder: port payloads, the front-to-back queue item and register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package pbg_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_ROW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS_PER_IMAGE = 1'b1;

    // Register reset values
    localparam logic [7:0] BYTES_PER_ROW_RST  = 8'd72;
    localparam logic [9:0] ROWS_PER_IMAGE_RST = 10'd720;

    // Decode constants
    localparam logic [7:0] SPACE_CODE      = 8'd128;
    localparam logic [7:0] MIN_ROW_BYTES   = 8'd16;
    localparam logic [7:0] REPEAT_HDR_MIN  = 8'h80;
    localparam logic [8:0] REPEAT_BASE     = 9'h101;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH_DEF = 4;

    // Input channel payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       image_start;
    } pbg_in_t;

    // Result channel payload
    typedef struct packed {
        logic       set_family;
        logic       family_value;
        logic [7:0] code_byte;
        logic [7:0] run_length;
        logic       row_end;
        logic       image_end;
        logic       last_result;
    } pbg_out_t;

    // One decoded pixel run handed from front to back
    typedef struct packed {
        logic [7:0] pixel;
        logic [7:0] count;
        logic       clear;
    } pbg_item_t;

endpackage

`default_nettype wire

// ----- rtl/pbg_front.sv -----
// ----------------------------------------------------------------------------
// pbg_front
// Run-length header decoder. Turns the compressed byte stream into pixel
// runs (pixel, count) and forwards a pending image clear with the next run.
// ----------------------------------------------------------------------------
`default_nettype none

module pbg_front
    import pbg_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    input  wire pbg_in_t   in_data,
    output logic           push,
    output pbg_item_t      push_item
);

    localparam logic [1:0] MODE_HEADER  = 2'd0;
    localparam logic [1:0] MODE_LITERAL = 2'd1;
    localparam logic [1:0] MODE_REPEAT  = 2'd2;

    logic [1:0] mode_reg, mode_next;
    logic [6:0] lit_reg, lit_next;
    logic [7:0] rep_reg, rep_next;
    logic       clr_pend_reg, clr_pend_next;

    logic [1:0] mode_eff;
    logic [6:0] lit_eff;
    logic [8:0] rep_calc;
    logic       clr_now;

    assign clr_now  = clr_pend_reg | in_data.image_start;
    assign mode_eff = in_data.image_start ? MODE_HEADER : mode_reg;
    assign lit_eff  = in_data.image_start ? 7'd0 : lit_reg;
    assign rep_calc = REPEAT_BASE - {1'b0, in_data.data_byte};

    // Decode one accepted byte
    always_comb begin
        mode_next       = mode_reg;
        lit_next        = lit_reg;
        rep_next        = rep_reg;
        clr_pend_next   = clr_pend_reg;
        push            = 1'b0;
        push_item.pixel = in_data.data_byte;
        push_item.count = 8'd1;
        push_item.clear = clr_now;
        if (in_valid) begin
            unique case (mode_eff)
                MODE_LITERAL: begin
                    push          = 1'b1;
                    clr_pend_next = 1'b0;
                    if (lit_eff == 7'd0) begin
                        mode_next = MODE_HEADER;
                    end else begin
                        lit_next = lit_eff - 7'd1;
                    end
                end
                MODE_REPEAT: begin
                    push            = 1'b1;
                    push_item.count = rep_reg;
                    clr_pend_next   = 1'b0;
                    mode_next       = MODE_HEADER;
                end
                default: begin
                    clr_pend_next = clr_now;
                    if (in_data.data_byte < REPEAT_HDR_MIN) begin
                        lit_next  = in_data.data_byte[6:0];
                        mode_next = MODE_LITERAL;
                    end else begin
                        rep_next  = rep_calc[7:0];
                        mode_next = MODE_REPEAT;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= MODE_HEADER;
            lit_reg      <= 7'd0;
            rep_reg      <= 8'd0;
            clr_pend_reg <= 1'b0;
        end else begin
            mode_reg     <= mode_next;
            lit_reg      <= lit_next;
            rep_reg      <= rep_next;
            clr_pend_reg <= clr_pend_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pbg_fifo.sv -----
// ----------------------------------------------------------------------------
// pbg_fifo
// Short queue of pixel runs between the decoder front and the run splitter.
// Head entry is presented combinationally from the storage registers.
// ----------------------------------------------------------------------------
`default_nettype none

module pbg_fifo
    import pbg_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire pbg_item_t push_item,
    output logic           full,
    input  wire logic      pop,
    output logic           head_valid,
    output pbg_item_t      head_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pbg_item_t          store_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = store_reg[rd_ptr_reg];

    // Write entry
    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/pbg_back.sv -----
// ----------------------------------------------------------------------------
// pbg_back
// Run splitter. Takes pixel runs from the queue, maps them to glyph codes,
// cuts them at row ends, flags the image end and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pbg_back
    import pbg_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic [7:0] bytes_per_row,
    input  wire logic [9:0] rows_per_image,
    input  wire logic      head_valid,
    input  wire pbg_item_t head_item,
    output logic           pop,
    output logic           out_valid,
    input  wire logic      out_ready,
    output pbg_out_t       out_data
);

    // Active run
    logic       act_valid_reg;
    logic       act_first_reg;
    logic       act_clr_reg;
    logic [7:0] act_pix_reg;
    logic [7:0] act_rem_reg;

    // Image position and family
    logic [7:0] col_reg;
    logic [9:0] row_reg;
    logic       fam_reg;
    logic       done_reg;

    // Output register
    logic       out_valid_reg;
    pbg_out_t   out_data_reg;

    logic [7:0] col_eff;
    logic [9:0] row_eff;
    logic       done_eff;
    logic [7:0] width;
    logic [7:0] room;
    logic [7:0] piece;
    logic [7:0] rem_left;
    logic [9:0] row_inc;
    logic       rend, iend;
    logic       slot_free, drop, emit, advance, finish;
    logic       pix_nz, fam_new, setf;
    pbg_out_t   res;

    assign col_eff  = act_clr_reg ? 8'd0 : col_reg;
    assign row_eff  = act_clr_reg ? 10'd0 : row_reg;
    assign done_eff = act_clr_reg ? 1'b0 : done_reg;

    // Size the next piece against the room left in the row
    assign width    = (bytes_per_row < MIN_ROW_BYTES) ? MIN_ROW_BYTES : bytes_per_row;
    assign room     = (width > col_eff) ? width - col_eff : 8'd1;
    assign piece    = (act_rem_reg < room) ? act_rem_reg : room;
    assign rend     = (piece == room);
    assign row_inc  = row_eff + 10'd1;
    assign iend     = rend && (row_inc >= rows_per_image);
    assign rem_left = act_rem_reg - piece;

    // Handshake between active run, queue and output register
    assign slot_free = !out_valid_reg || out_ready;
    assign drop      = done_eff;
    assign emit      = act_valid_reg && !drop && slot_free;
    assign advance   = act_valid_reg && (drop || slot_free);
    assign finish    = drop || iend || (rem_left == 8'd0);
    assign pop       = head_valid && (!act_valid_reg || (advance && finish));

    // Family switch on the first piece of a nonzero pixel
    assign pix_nz  = |act_pix_reg;
    assign fam_new = (act_first_reg && pix_nz) ? act_pix_reg[7] : fam_reg;
    assign setf    = act_first_reg && pix_nz && (act_pix_reg[7] != fam_reg);

    always_comb begin
        res.set_family   = setf;
        res.family_value = fam_new;
        res.code_byte    = pix_nz ? {1'b0, act_pix_reg[6:0]} : SPACE_CODE;
        res.run_length   = piece;
        res.row_end      = rend;
        res.image_end    = iend;
        res.last_result  = finish;
    end

    // Active run and position state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_valid_reg <= 1'b0;
            act_first_reg <= 1'b0;
            act_clr_reg   <= 1'b0;
            act_rem_reg   <= 8'd0;
            col_reg       <= 8'd0;
            row_reg       <= 10'd0;
            fam_reg       <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            if (emit) begin
                col_reg  <= rend ? 8'd0 : col_eff + piece;
                row_reg  <= rend ? row_inc : row_eff;
                done_reg <= iend;
                fam_reg  <= fam_new;
            end
            if (pop) begin
                act_valid_reg <= 1'b1;
                act_first_reg <= 1'b1;
                act_clr_reg   <= head_item.clear;
                act_rem_reg   <= head_item.count;
            end else begin
                if (emit) begin
                    act_first_reg <= 1'b0;
                    act_clr_reg   <= 1'b0;
                    act_rem_reg   <= rem_left;
                end
                if (advance && finish) begin
                    act_valid_reg <= 1'b0;
                end
            end
        end
    end

    // Pixel of the active run
    always_ff @(posedge aclk) begin
        if (pop) begin
            act_pix_reg <= head_item.pixel;
        end
    end

    // Hold a result until the transfer completes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (emit) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ----- rtl/packbits_to_glyph_code_stream.sv -----
// A byte's first result passes the run queue, active run and output registers to m_valid.
// Throughput: one input byte per cycle while the run queue is not full; a pixel run
// leaves as one result per cycle per row piece while m_ready is high, so runs that
// cross row ends hold the splitter longer. The 4-entry run queue lets the decoder
// keep taking bytes meanwhile. Reset (aresetn low, synchronous) empties queue and
// output and restores the register defaults 72 bytes per row and 720 rows per image.
// ----------------------------------------------------------------------------
// packbits_to_glyph_code_stream
// Decodes a run-length compressed pixel stream into runs of glyph codes,
// split at row ends and flagged at the end of the image.
// ----------------------------------------------------------------------------
`default_nettype none

module packbits_to_glyph_code_stream
    import pbg_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire pbg_in_t               s_data,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output pbg_out_t                   m_data
);

    logic [7:0] bytes_per_row_reg;
    logic [9:0] rows_per_image_reg;

    logic       q_full, q_push, q_pop, q_head_valid;
    pbg_item_t  q_push_item, q_head_item;
    logic       in_xfer;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bytes_per_row_reg  <= BYTES_PER_ROW_RST;
            rows_per_image_reg <= ROWS_PER_IMAGE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_BYTES_PER_ROW:  bytes_per_row_reg  <= cfg_data[7:0];
                REG_ROWS_PER_IMAGE: rows_per_image_reg <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    assign s_ready = !q_full;
    assign in_xfer = s_valid && s_ready;

    pbg_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (in_xfer),
        .in_data   (s_data),
        .push      (q_push),
        .push_item (q_push_item)
    );

    pbg_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_item  (q_push_item),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_item  (q_head_item)
    );

    pbg_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .bytes_per_row  (bytes_per_row_reg),
        .rows_per_image (rows_per_image_reg),
        .head_valid     (q_head_valid),
        .head_item      (q_head_item),
        .pop            (q_pop),
        .out_valid      (m_valid),
        .out_ready      (m_ready),
        .out_data       (m_data)
    );

endmodule

`default_nettype wire

// ----- tb/pbg_run_checker.sv -----
// ----------------------------------------------------------------------------
// pbg_run_checker
// Watches the register port and both streaming channels of the glyph code
// decoder, predicts the code runs for every byte transfer and compares each
// result transfer, field by field, with the oldest predicted run.
// ----------------------------------------------------------------------------

module pbg_run_checker
    import pbg_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  pbg_in_t               s_data,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  pbg_out_t              m_data,
    output int                    fail_count,
    output int                    outstanding,
    output int                    decoded_bytes,
    output int                    results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        EXPECT_HEADER,
        COPY_LITERAL,
        COPY_REPEAT
    } decode_mode_t;

    // Register copies
    logic [7:0]   row_bytes;
    logic [9:0]   rows_limit;

    // Decoder and raster position
    decode_mode_t mode;
    logic [6:0]   literal_left;
    int           repeat_count;
    int           column;
    int           row;
    logic         family;
    logic         image_done;

    pbg_out_t     runs_due[$];
    pbg_out_t     want;

    initial begin
        fail_count    = 0;
        outstanding   = 0;
        decoded_bytes = 0;
        results_seen  = 0;
    end

    // Split one pixel run at row ends and queue the pieces
    function automatic void split_pixel_run(input logic [7:0] pixel, input int count);
        int         width;
        int         room;
        int         piece;
        int         pieces;
        logic       switch_family;
        logic [7:0] code;
        pbg_out_t   run;
        width = (row_bytes < MIN_ROW_BYTES) ? int'(MIN_ROW_BYTES) : int'(row_bytes);
        code = SPACE_CODE;
        switch_family = 1'b0;
        if (pixel != 8'h00) begin
            code = {1'b0, pixel[6:0]};
            if (pixel[7] != family) begin
                family = pixel[7];
                switch_family = 1'b1;
            end
        end
        pieces = 0;
        while (count > 0 && pieces < 10) begin
            room  = (width > column) ? width - column : 1;
            piece = (count < room) ? count : room;
            count -= piece;
            column += piece;
            run = '0;
            if (piece == room) begin
                run.row_end = 1'b1;
                column = 0;
                row = (row + 1) % 1024;
                // Last row reached: drop whatever remains of the run
                if (row >= int'(rows_limit)) begin
                    run.image_end = 1'b1;
                    image_done = 1'b1;
                    count = 0;
                end
            end
            column = column % 256;
            run.set_family   = switch_family;
            run.family_value = family;
            run.code_byte    = code;
            run.run_length   = 8'(piece);
            run.last_result  = (count == 0 || pieces == 9);
            switch_family = 1'b0;
            runs_due.push_back(run);
            pieces++;
        end
    endfunction

    // Advance the decoder by one accepted byte
    function automatic void decode_stream_byte(input pbg_in_t item);
        int count;
        if (item.image_start) begin
            mode         = EXPECT_HEADER;
            literal_left = '0;
            repeat_count = 0;
            column       = 0;
            row          = 0;
            image_done   = 1'b0;
        end
        if (!image_done) begin
            decoded_bytes++;
            case (mode)
                COPY_LITERAL: begin
                    if (literal_left == 0)
                        mode = EXPECT_HEADER;
                    else
                        literal_left = literal_left - 7'd1;
                    split_pixel_run(item.data_byte, 1);
                end
                COPY_REPEAT: begin
                    count = repeat_count;
                    mode = EXPECT_HEADER;
                    repeat_count = 0;
                    split_pixel_run(item.data_byte, count);
                end
                default: begin
                    if (item.data_byte < REPEAT_HDR_MIN) begin
                        literal_left = item.data_byte[6:0];
                        mode = COPY_LITERAL;
                    end else begin
                        repeat_count = (int'(REPEAT_BASE) - int'(item.data_byte)) % 256;
                        mode = COPY_REPEAT;
                    end
                end
            endcase
        end
    endfunction

    task automatic compare_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            $error("%s: expected %0d, got %0d", name, expected, actual);
            fail_count++;
        end
    endtask

    // Track registers, check results, then predict from the input transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            row_bytes    = BYTES_PER_ROW_RST;
            rows_limit   = ROWS_PER_IMAGE_RST;
            mode         = EXPECT_HEADER;
            literal_left = '0;
            repeat_count = 0;
            column       = 0;
            row          = 0;
            family       = 1'b0;
            image_done   = 1'b0;
            runs_due.delete();
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_BYTES_PER_ROW:  row_bytes  = cfg_data[7:0];
                    REG_ROWS_PER_IMAGE: rows_limit = cfg_data[9:0];
                    default: ;
                endcase
            end
            if (m_valid && m_ready) begin
                results_seen++;
                if (runs_due.size() == 0) begin
                    $error("result transfer with no run expected: code %0d length %0d",
                           m_data.code_byte, m_data.run_length);
                    fail_count++;
                end else begin
                    want = runs_due.pop_front();
                    compare_field("set_family", want.set_family, m_data.set_family);
                    compare_field("family_value", want.family_value, m_data.family_value);
                    compare_field("code_byte", want.code_byte, m_data.code_byte);
                    compare_field("run_length", want.run_length, m_data.run_length);
                    compare_field("row_end", want.row_end, m_data.row_end);
                    compare_field("image_end", want.image_end, m_data.image_end);
                    compare_field("last_result", want.last_result, m_data.last_result);
                end
            end
            if (s_valid && s_ready)
                decode_stream_byte(s_data);
        end
        outstanding = runs_due.size();
    end

endmodule

// ----- tb/packbits_to_glyph_code_stream_tb.sv -----
// ----------------------------------------------------------------------------
// packbits_to_glyph_code_stream_tb
// Drives compressed pixel bytes into the glyph code decoder through a series
// of row width and row count settings, with random gaps on both channels and
// one long output hold-off; the run checker predicts and compares results.
// ----------------------------------------------------------------------------

module packbits_to_glyph_code_stream_tb;
    import pbg_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 400;
    localparam int END_WAIT      = 20000;

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    pbg_in_t               s_data;
    logic                  m_valid;
    logic                  m_ready;
    pbg_out_t              m_data;

    int   fail_count;
    int   outstanding;
    int   decoded_bytes;
    int   results_seen;
    int   n_settings = 0;
    int   n_sent = 0;
    logic calm = 1'b0;
    logic hold_off_req = 1'b0;

    packbits_to_glyph_code_stream i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    pbg_run_checker i_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .decoded_bytes (decoded_bytes),
        .results_seen  (results_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Hard stop for a hung run
    initial begin
        #3_000_000;
        $display("status: fail");
        $finish;
    end

    // Result side: random stalls, one long hold-off on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_off_req = 1'b0;
            end
            m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 38);
        end
    end

    function automatic logic [7:0] rand_pixel();
        return ($urandom_range(99) < 20) ? 8'h00 : 8'($urandom_range(1, 255));
    endfunction

    // Offer one byte after a random gap and hold it until the transfer
    task automatic send_byte(input logic [7:0] value, input logic start);
        if (!calm) begin
            while ($urandom_range(99) < 38) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= '{data_byte: value, image_start: start};
        do @(posedge aclk); while (!s_ready);
        n_sent++;
        @(negedge aclk);
    endtask

    // Drain, then write both registers while the block is idle
    task automatic reconfigure(input logic [7:0] width_val, input logic [9:0] rows_val);
        s_valid <= 1'b0;
        while (outstanding != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_BYTES_PER_ROW;
        cfg_data  <= {2'($urandom_range(3)), width_val};
        @(negedge aclk);
        cfg_index <= REG_ROWS_PER_IMAGE;
        cfg_data  <= rows_val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Mostly well-formed packets with random content, some noise and cut packets
    task automatic send_random_packets(input int n_bytes);
        int   goal;
        int   len;
        int   pick;
        int   k;
        logic fresh;
        goal  = n_sent + n_bytes;
        fresh = 1'b1;
        while (n_sent < goal) begin
            pick = $urandom_range(99);
            if (pick < 10) begin
                send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
            end else if (pick < 55) begin
                len = ($urandom_range(3) == 0) ? $urandom_range(127) : $urandom_range(7);
                send_byte(8'(len), fresh || ($urandom_range(99) < 12));
                for (k = 0; k <= len && n_sent < goal; k++) begin
                    if ($urandom_range(99) < 3)
                        break;
                    send_byte(rand_pixel(), 1'b0);
                end
            end else begin
                send_byte(8'($urandom_range(128, 255)), fresh || ($urandom_range(99) < 12));
                send_byte(rand_pixel(), 1'b0);
            end
            fresh = 1'b0;
        end
    endtask

    initial begin
        int guard;
        aresetn   = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        s_valid   = 1'b0;
        s_data    = '0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Narrow rows, two-row images
        reconfigure(8'd16, 10'd2);
        send_byte(8'h00, 1'b1);        // one literal
        send_byte(8'h00, 1'b0);        // zero pixel becomes space, family kept
        send_byte(8'h01, 1'b0);        // two literals
        send_byte(8'hff, 1'b0);        // family switch to high half
        send_byte(8'h80, 1'b0);        // code zero in the high family
        send_byte(8'h80, 1'b0);        // longest repeat
        send_byte(8'h01, 1'b0);        // splits over two rows, ends image, rest dropped
        send_byte(8'h7f, 1'b0);        // ignored after image end
        send_byte(8'h55, 1'b0);
        send_byte(8'hff, 1'b1);        // new image, shortest repeat
        send_byte(8'h81, 1'b0);
        send_byte(8'h7f, 1'b0);        // longest literal header, cut short below
        send_byte(8'h00, 1'b0);
        send_byte(8'hfe, 1'b0);
        send_byte(8'h81, 1'b1);        // new image abandons the literal
        send_byte(8'h00, 1'b0);

        // Row width shrunk below the current column
        reconfigure(8'd40, 10'd1023);
        send_byte(8'hec, 1'b1);
        send_byte(8'h40, 1'b0);
        reconfigure(8'd16, 10'd1023);
        send_byte(8'h00, 1'b0);
        send_byte(8'h33, 1'b0);

        // Width below the minimum and a zero row count
        reconfigure(8'd3, 10'd0);
        send_byte(8'hf0, 1'b1);
        send_byte(8'h22, 1'b0);

        // Random phases over several settings
        send_random_packets(30);
        calm = 1'b1;
        reconfigure(8'd255, 10'd1023);
        send_random_packets(40);
        calm = 1'b0;
        reconfigure(8'd72, 10'd720);
        send_random_packets(40);
        reconfigure(8'd24, 10'd6);
        hold_off_req = 1'b1;
        send_random_packets(50);
        reconfigure(8'd16, 10'd1);
        send_random_packets(40);

        // Drain and look for stray results
        s_valid <= 1'b0;
        guard = 0;
        while (outstanding != 0 && guard < END_WAIT) begin
            @(negedge aclk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(negedge aclk);
        if (outstanding != 0)
            $error("%0d expected runs never arrived", outstanding);

        $display("Decoded %0d bytes into %0d code runs over %0d register settings,",
                 decoded_bytes, results_seen, n_settings);
        $display("with random gaps, an idle-free stretch and a long output hold-off.");
        if (fail_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/pbg_pkg.sv
rtl/pbg_front.sv
rtl/pbg_fifo.sv
rtl/pbg_back.sv
rtl/packbits_to_glyph_code_stream.sv
tb/pbg_run_checker.sv
tb/packbits_to_glyph_code_stream_tb.sv
